FILE: src/zcu_pkg.sv
// Shared types, constants and helper functions for the zigzag Cantor unrank block.
package zcu_pkg;

  localparam int POS_WIDTH          = 60;
  localparam int OUT_WIDTH          = 31;
  localparam int INDEX_WIDTH_DEF    = 60;
  localparam int DIAG_LIMIT_DEF     = 2000000000;

  // bits needed for a diagonal count that may reach the limit plus one
  function automatic int zcu_diag_width(input longint limit);
    return $clog2(limit + 2);
  endfunction

  function automatic int zcu_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } zcu_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } zcu_cmd_t;

endpackage

FILE: src/zcu_datapath.sv
// Datapath: bitwise diagonal search by shift-add triangular numbers, then offset and output.
module zcu_datapath #(
  parameter int INDEX_WIDTH = zcu_pkg::INDEX_WIDTH_DEF,
  parameter int DIAG_LIMIT  = zcu_pkg::DIAG_LIMIT_DEF
) (
  input  logic                            clk,
  input  zcu_pkg::zcu_cmd_t               cmd,
  input  logic [zcu_pkg::POS_WIDTH-1:0]   in_position,
  output logic [zcu_pkg::OUT_WIDTH-1:0]   numerator,
  output logic [zcu_pkg::OUT_WIDTH-1:0]   denominator
);
  import zcu_pkg::*;

  localparam int DW = zcu_diag_width(DIAG_LIMIT);
  localparam int TW = 2 * DW;
  localparam int OW = OUT_WIDTH;
  localparam int CW = zcu_max(zcu_max(TW, INDEX_WIDTH), OW);
  localparam int PW = zcu_max(POS_WIDTH, INDEX_WIDTH);

  localparam logic [DW-1:0] C_INIT   = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [TW-1:0] CSQ_INIT = {2'b01, {(TW - 2){1'b0}}};
  localparam logic [TW:0]   TC_SUM   = (TW + 1)'(CSQ_INIT) + (TW + 1)'(C_INIT);
  localparam logic [TW-1:0] TC_INIT  = TC_SUM[TW:1];
  localparam logic [CW-1:0] LIMIT_C  = CW'(DIAG_LIMIT);
  localparam logic [OW-1:0] TWO      = OW'(2);

  logic [INDEX_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]          hi_r, hi_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [DW-1:0]          c_r, c_nxt;
  logic [TW-1:0]          t_r, t_nxt;
  logic [TW-1:0]          ac_r, ac_nxt;
  logic [TW-1:0]          csq_r, csq_nxt;
  logic [TW-1:0]          tc_r, tc_nxt;
  logic [OW-1:0]          num_r, num_nxt;
  logic [OW-1:0]          den_r, den_nxt;

  logic [PW-1:0]          pos_ext;
  logic [CW-1:0]          n_in_ext;
  logic [DW-1:0]          cand;
  logic [TW-1:0]          tri_cand;
  logic                   take;
  logic [TW:0]            ac_sum;
  logic [TW-1:0]          tc_sum;
  logic [CW-1:0]          k_full;
  logic [OW-1:0]          k_low;
  logic [OW-1:0]          other;

  assign pos_ext  = PW'(in_position);
  assign n_in_ext = CW'(pos_ext[INDEX_WIDTH-1:0]);

  // tri(d + c) = tri(d) + d*c + tri(c), with c a power of two
  assign cand     = d_r | c_r;
  assign tri_cand = t_r + ac_r + tc_r;
  assign take     = (cand <= hi_r) && (CW'(tri_cand) < CW'(n_r));
  assign ac_sum   = (TW + 1)'(ac_r) + (TW + 1)'(csq_r);
  assign tc_sum   = (csq_r >> 2) + TW'(c_r >> 1);

  assign k_full   = CW'(n_r) - CW'(t_r);
  assign k_low    = k_full[OW-1:0];
  assign other    = OW'(d_r) + TWO - k_low;

  always_comb begin
    n_nxt   = n_r;
    hi_nxt  = hi_r;
    d_nxt   = d_r;
    c_nxt   = c_r;
    t_nxt   = t_r;
    ac_nxt  = ac_r;
    csq_nxt = csq_r;
    tc_nxt  = tc_r;
    num_nxt = num_r;
    den_nxt = den_r;
    if (cmd.load) begin
      n_nxt   = pos_ext[INDEX_WIDTH-1:0];
      hi_nxt  = (n_in_ext < LIMIT_C) ? n_in_ext[DW-1:0] : LIMIT_C[DW-1:0];
      d_nxt   = '0;
      c_nxt   = C_INIT;
      t_nxt   = '0;
      ac_nxt  = '0;
      csq_nxt = CSQ_INIT;
      tc_nxt  = TC_INIT;
    end
    if (cmd.step) begin
      if (take) begin
        d_nxt  = cand;
        t_nxt  = tri_cand;
        ac_nxt = ac_sum[TW:1];
      end else begin
        ac_nxt = ac_r >> 1;
      end
      c_nxt   = c_r >> 1;
      csq_nxt = csq_r >> 2;
      tc_nxt  = tc_sum >> 1;
    end
    if (cmd.finish) begin
      // diagonal is d+1: even diagonal when d is odd
      if (d_r[0]) begin
        num_nxt = other;
        den_nxt = k_low;
      end else begin
        num_nxt = k_low;
        den_nxt = other;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    hi_r  <= hi_nxt;
    d_r   <= d_nxt;
    c_r   <= c_nxt;
    t_r   <= t_nxt;
    ac_r  <= ac_nxt;
    csq_r <= csq_nxt;
    tc_r  <= tc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign numerator   = num_r;
  assign denominator = den_r;

endmodule

FILE: src/zcu_ctrl.sv
// Controller: sequences load, search steps and output transfer.
module zcu_ctrl #(
  parameter int DIAG_LIMIT = zcu_pkg::DIAG_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output zcu_pkg::zcu_cmd_t cmd
);
  import zcu_pkg::*;

  localparam int DW   = zcu_diag_width(DIAG_LIMIT);
  localparam int CNTW = $clog2(DW);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

  zcu_state_t      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_LAST;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/zigzag_cantor_unrank.sv
// Top level of the zigzag Cantor table unrank block.
// Maps a 1-based position in the zigzag walk of the fraction table to its fraction.
// Each item runs in order: the position is taken, then DW steps (DW = 31 at the default
// DIAG_LIMIT) of the shift-add triangular-number search run (one diagonal bit per
// step), and finally the offset is formed and the result register is loaded.
// That last step is held off while the previous result has not been transferred.
// A finished result waits in its register while the next position is taken.
module zigzag_cantor_unrank #(
  parameter int INDEX_WIDTH = zcu_pkg::INDEX_WIDTH_DEF,
  parameter int DIAG_LIMIT  = zcu_pkg::DIAG_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zcu_pkg::POS_WIDTH-1:0] in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zcu_pkg::OUT_WIDTH-1:0] out_numerator,
  output logic [zcu_pkg::OUT_WIDTH-1:0] out_denominator
);
  import zcu_pkg::*;

  zcu_cmd_t cmd;

  zcu_ctrl #(
    .DIAG_LIMIT (DIAG_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  zcu_datapath #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .DIAG_LIMIT  (DIAG_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_position (in_position),
    .numerator   (out_numerator),
    .denominator (out_denominator)
  );

endmodule

FILE: src/zcu_checker.sv
// Port-level checker for the zigzag Cantor unrank block, with its bind.
module zcu_checker #(
  parameter int DIAG_LIMIT = zcu_pkg::DIAG_LIMIT_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [zcu_pkg::OUT_WIDTH-1:0] out_numerator,
  input logic [zcu_pkg::OUT_WIDTH-1:0] out_denominator
);
  import zcu_pkg::*;

  localparam int DW = zcu_diag_width(DIAG_LIMIT);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_numerator) && $stable(out_denominator))
    else $error("result changed while stalled");

  // still busy at the end of the search that follows an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##(DW + 1) !in_ready)
    else $error("input taken during search");

  // a new result only appears while the block is busy
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // returning to idle always leaves a result behind
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("idle without result");

endmodule

bind zigzag_cantor_unrank zcu_checker #(
  .DIAG_LIMIT (DIAG_LIMIT)
) u_zcu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_numerator   (out_numerator),
  .out_denominator (out_denominator)
);
